@@ hw/rtl/etrd_pkg.sv @@
// Shared types and constants for the ESC throttle ramp drive.
// Used by esc_throttle_ramp_drive; depends on nothing else.
`timescale 1ns / 1ps

package etrd_pkg;

    // Field widths
    localparam int PULSE_W    = 12;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int DUTY_W     = 7;
    localparam int DRIVE_W    = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Bit-serial duty map: |pulse offset| (12b) times |duty span| (7b), then divide
    localparam int SPAN_W    = 7;
    localparam int PROD_W    = PULSE_W + SPAN_W;
    localparam int MUL_STEPS = SPAN_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = 5;

    // Slew arithmetic range: -4095 .. 8190
    localparam int SLEW_W = PULSE_W + 2;

    localparam logic [PULSE_W-1:0] FULL_FWD_PULSE  = 12'd2000;
    localparam logic [PULSE_W-1:0] FULL_REV_PULSE  = 12'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX       = 12'd4095;
    localparam logic [DUTY_W-1:0]  DRAG_BRAKE_DUTY = 7'd10;
    localparam logic [DUTY_W-1:0]  DUTY_LIMIT      = 7'd100;

    // Register reset values
    localparam logic [PULSE_W-1:0]    RST_NEUTRAL_LOW    = 12'd1480;
    localparam logic [PULSE_W-1:0]    RST_NEUTRAL_HIGH   = 12'd1520;
    localparam logic [PULSE_W-1:0]    RST_NEUTRAL_CENTER = 12'd1500;
    localparam logic [INTERVAL_W-1:0] RST_RAMP_INTERVAL  = 16'd20;
    localparam logic [PULSE_W-1:0]    RST_ACCEL_STEP     = 12'd10;
    localparam logic [PULSE_W-1:0]    RST_DECEL_STEP     = 12'd10;
    localparam logic [DUTY_W-1:0]     RST_DUTY_FLOOR     = 7'd0;
    localparam logic [DUTY_W-1:0]     RST_DUTY_CEILING   = 7'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING   = 3'd7;

    // Drive kind codes
    localparam logic [KIND_W-1:0] KIND_BRAKE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FWD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REV   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MAP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        RAMP_STOPPED   = 2'd0,
        RAMP_FORWARD   = 2'd1,
        RAMP_REVERSE   = 2'd2,
        RAMP_EMERGENCY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RGN_BRAKE,
        RGN_FWD,
        RGN_REV
    } region_t;

endpackage

@@ hw/rtl/esc_throttle_ramp_drive.sv @@
// ESC throttle ramp drive: arming, slew limiting and duty mapping of an RC pulse.
// Depends on etrd_pkg for widths, codes and reset values.
`timescale 1ns / 1ps

// One request in, one result out. A request is taken only in idle, so the next one
// waits until the last is through. When the held pulse lies outside the neutral band
// it runs through the 7-step shift-add multiply and the 19-step restoring divide of
// the linear duty map; inside the band or with a zero pulse span both are skipped.
// The result sits in an output register, so the next request is taken while the
// previous result still waits on m_ready. Configuration writes are always
// accepted (cfg_ready is tied high) and must only happen while the block is idle.
module esc_throttle_ramp_drive (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [etrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [etrd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [etrd_pkg::PULSE_W-1:0]         s_pulse_width,
    input  logic [etrd_pkg::TIME_W-1:0]          s_time_ms,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [etrd_pkg::PULSE_W-1:0]         m_ramped_pulse,
    output logic [etrd_pkg::KIND_W-1:0]          m_drive_kind,
    output logic [etrd_pkg::DUTY_W-1:0]          m_channel_duty,
    output logic signed [etrd_pkg::DRIVE_W-1:0]  m_signed_drive
);

    localparam int PW = etrd_pkg::PULSE_W;
    localparam int SW = etrd_pkg::SLEW_W;
    localparam int QW = etrd_pkg::PROD_W;
    localparam int DW = etrd_pkg::DUTY_W;

    // Configuration registers
    logic [PW-1:0]                       neutral_low_reg;
    logic [PW-1:0]                       neutral_high_reg;
    logic [PW-1:0]                       neutral_center_reg;
    logic [etrd_pkg::INTERVAL_W-1:0]     ramp_interval_reg;
    logic [PW-1:0]                       accel_step_reg;
    logic [PW-1:0]                       decel_step_reg;
    logic [DW-1:0]                       duty_floor_reg;
    logic [DW-1:0]                       duty_ceiling_reg;

    // Control and ramp state
    etrd_pkg::state_t  state_reg, state_next;
    etrd_pkg::mode_t   ramp_mode_reg, ramp_mode_next;
    etrd_pkg::region_t region_reg, region_next;
    logic              armed_reg, armed_next;
    logic [PW-1:0]     last_target_reg, last_target_next;
    logic [etrd_pkg::TIME_W-1:0] last_update_reg, last_update_next;
    logic [PW-1:0]     held_pulse_reg, held_pulse_next;
    logic [etrd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    // Request and datapath registers
    logic [PW-1:0]                 pw_reg, pw_next;
    logic [etrd_pkg::TIME_W-1:0]   time_reg, time_next;
    logic [QW-1:0]                 acc_reg, acc_next;
    logic [QW-1:0]                 mcand_reg, mcand_next;
    logic [etrd_pkg::SPAN_W-1:0]   mplier_reg, mplier_next;
    logic [PW-1:0]                 den_reg, den_next;
    logic [PW-1:0]                 rem_reg, rem_next;
    logic                          q_neg_reg, q_neg_next;
    logic                          den_zero_reg, den_zero_next;

    // Output registers
    logic [PW-1:0]                     out_pulse_reg, out_pulse_next;
    logic [etrd_pkg::KIND_W-1:0]       out_kind_reg, out_kind_next;
    logic [DW-1:0]                     out_duty_reg, out_duty_next;
    logic signed [etrd_pkg::DRIVE_W-1:0] out_drive_reg, out_drive_next;

    // Step stage helpers
    logic                          in_band;
    logic                          armed_now;
    logic [etrd_pkg::TIME_W-1:0]   elapsed;
    logic                          update_due;
    etrd_pkg::mode_t               mode_sel;
    logic signed [SW-1:0]          in_s, last_s;
    logic signed [SW-1:0]          up_acc_s, dn_acc_s, up_dec_s, dn_dec_s;
    logic signed [SW-1:0]          slew_s;
    logic [PW-1:0]                 slew_val;

    // Map stage helpers
    logic                          map_fwd, map_rev;
    logic [PW-1:0]                 map_edge, map_full;
    logic [PW-1:0]                 num_mag;
    logic [PW:0]                   den_diff;
    logic [PW-1:0]                 den_mag;
    logic [DW:0]                   span_diff;
    logic [DW-1:0]                 span_mag;

    // Divide step helpers
    logic [PW:0]                   rem_shift;
    logic [PW+1:0]                 trial;
    logic                          borrow;

    // Finish helpers
    logic [DW-1:0]                 q_sat;
    logic signed [DW+1:0]          d_s;
    logic [DW-1:0]                 duty_lin;
    logic [DW-1:0]                 duty_direct;
    logic [DW-1:0]                 duty_sel;
    logic signed [etrd_pkg::DRIVE_W-1:0] duty_s;
    logic                          out_free;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == etrd_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_ramped_pulse = out_pulse_reg;
    assign m_drive_kind   = out_kind_reg;
    assign m_channel_duty = out_duty_reg;
    assign m_signed_drive = out_drive_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_low_reg    <= etrd_pkg::RST_NEUTRAL_LOW;
            neutral_high_reg   <= etrd_pkg::RST_NEUTRAL_HIGH;
            neutral_center_reg <= etrd_pkg::RST_NEUTRAL_CENTER;
            ramp_interval_reg  <= etrd_pkg::RST_RAMP_INTERVAL;
            accel_step_reg     <= etrd_pkg::RST_ACCEL_STEP;
            decel_step_reg     <= etrd_pkg::RST_DECEL_STEP;
            duty_floor_reg     <= etrd_pkg::RST_DUTY_FLOOR;
            duty_ceiling_reg   <= etrd_pkg::RST_DUTY_CEILING;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                etrd_pkg::CFG_NEUTRAL_LOW:    neutral_low_reg    <= cfg_data[PW-1:0];
                etrd_pkg::CFG_NEUTRAL_HIGH:   neutral_high_reg   <= cfg_data[PW-1:0];
                etrd_pkg::CFG_NEUTRAL_CENTER: neutral_center_reg <= cfg_data[PW-1:0];
                etrd_pkg::CFG_RAMP_INTERVAL:
                    ramp_interval_reg <= cfg_data[etrd_pkg::INTERVAL_W-1:0];
                etrd_pkg::CFG_ACCEL_STEP:     accel_step_reg     <= cfg_data[PW-1:0];
                etrd_pkg::CFG_DECEL_STEP:     decel_step_reg     <= cfg_data[PW-1:0];
                etrd_pkg::CFG_DUTY_FLOOR:     duty_floor_reg     <= cfg_data[DW-1:0];
                etrd_pkg::CFG_DUTY_CEILING:   duty_ceiling_reg   <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- step: arming and slew ----------------
    assign in_band    = (pw_reg > neutral_low_reg) && (pw_reg < neutral_high_reg);
    assign armed_now  = armed_reg || in_band;
    assign elapsed    = time_reg - last_update_reg;
    assign update_due = elapsed > {{(etrd_pkg::TIME_W-etrd_pkg::INTERVAL_W){1'b0}},
                                   ramp_interval_reg};

    assign in_s     = $signed({2'b00, pw_reg});
    assign last_s   = $signed({2'b00, last_target_reg});
    assign up_acc_s = last_s + $signed({2'b00, accel_step_reg});
    assign dn_acc_s = last_s - $signed({2'b00, accel_step_reg});
    assign up_dec_s = last_s + $signed({2'b00, decel_step_reg});
    assign dn_dec_s = last_s - $signed({2'b00, decel_step_reg});

    // Sticky mode: emergency is left only through the neutral band
    always_comb begin
        if (last_target_reg > neutral_high_reg &&
            ramp_mode_reg != etrd_pkg::RAMP_EMERGENCY) begin
            mode_sel = etrd_pkg::RAMP_FORWARD;
        end else if (last_target_reg < neutral_low_reg &&
                     ramp_mode_reg != etrd_pkg::RAMP_EMERGENCY) begin
            mode_sel = etrd_pkg::RAMP_REVERSE;
        end else if (last_target_reg >= neutral_low_reg &&
                     last_target_reg <= neutral_high_reg) begin
            mode_sel = etrd_pkg::RAMP_STOPPED;
        end else begin
            mode_sel = etrd_pkg::RAMP_EMERGENCY;
        end
    end

    // Later limit wins: downward after upward in stopped and forward mode, upward after downward in reverse
    always_comb begin
        slew_s = in_s;
        case (mode_sel)
            etrd_pkg::RAMP_STOPPED: begin
                if (in_s > up_acc_s) slew_s = up_acc_s;
                if (in_s < dn_acc_s) slew_s = dn_acc_s;
            end
            etrd_pkg::RAMP_FORWARD: begin
                if (in_s > up_acc_s) slew_s = up_acc_s;
                if (in_s < dn_dec_s) slew_s = dn_dec_s;
            end
            etrd_pkg::RAMP_REVERSE: begin
                if (in_s < dn_acc_s) slew_s = dn_acc_s;
                if (in_s > up_dec_s) slew_s = up_dec_s;
            end
            default: slew_s = in_s;
        endcase
        if (slew_s < 0) begin
            slew_val = '0;
        end else if (slew_s > $signed({2'b00, etrd_pkg::PULSE_MAX})) begin
            slew_val = etrd_pkg::PULSE_MAX;
        end else begin
            slew_val = slew_s[PW-1:0];
        end
    end

    // ---------------- map: operand setup ----------------
    assign map_fwd   = held_pulse_reg > neutral_high_reg;
    assign map_rev   = !map_fwd && (held_pulse_reg < neutral_low_reg);
    assign map_edge  = map_fwd ? neutral_high_reg : neutral_low_reg;
    assign map_full  = map_fwd ? etrd_pkg::FULL_FWD_PULSE : etrd_pkg::FULL_REV_PULSE;
    assign num_mag   = map_fwd ? (held_pulse_reg - neutral_high_reg)
                               : (neutral_low_reg - held_pulse_reg);
    assign den_diff  = {1'b0, map_full} - {1'b0, map_edge};
    assign den_mag   = den_diff[PW] ? (~den_diff[PW-1:0] + 1'b1) : den_diff[PW-1:0];
    assign span_diff = {1'b0, duty_ceiling_reg} - {1'b0, duty_floor_reg};
    assign span_mag  = span_diff[DW] ? (~span_diff[DW-1:0] + 1'b1) : span_diff[DW-1:0];

    // ---------------- divide: one quotient bit per cycle ----------------
    assign rem_shift = {rem_reg, acc_reg[QW-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, den_reg};
    assign borrow    = trial[PW+1];

    // ---------------- finish: offset, clamp, drive kind ----------------
    assign q_sat = (|acc_reg[QW-1:DW]) ? {DW{1'b1}} : acc_reg[DW-1:0];
    assign d_s   = q_neg_reg ? ($signed({2'b00, duty_floor_reg}) - $signed({2'b00, q_sat}))
                             : ($signed({2'b00, duty_floor_reg}) + $signed({2'b00, q_sat}));

    always_comb begin
        if (d_s < 0) begin
            duty_lin = '0;
        end else if (d_s > $signed({2'b00, etrd_pkg::DUTY_LIMIT})) begin
            duty_lin = etrd_pkg::DUTY_LIMIT;
        end else begin
            duty_lin = d_s[DW-1:0];
        end
    end

    assign duty_direct = (duty_ceiling_reg > etrd_pkg::DUTY_LIMIT) ? etrd_pkg::DUTY_LIMIT
                                                                   : duty_ceiling_reg;
    assign duty_sel    = den_zero_reg ? duty_direct : duty_lin;
    assign duty_s      = $signed({1'b0, duty_sel});
    assign out_free    = !m_valid_reg || m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next       = state_reg;
        ramp_mode_next   = ramp_mode_reg;
        region_next      = region_reg;
        armed_next       = armed_reg;
        last_target_next = last_target_reg;
        last_update_next = last_update_reg;
        held_pulse_next  = held_pulse_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg;
        pw_next          = pw_reg;
        time_next        = time_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        q_neg_next       = q_neg_reg;
        den_zero_next    = den_zero_reg;
        out_pulse_next   = out_pulse_reg;
        out_kind_next    = out_kind_reg;
        out_duty_next    = out_duty_reg;
        out_drive_next   = out_drive_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            etrd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    pw_next    = s_pulse_width;
                    time_next  = s_time_ms;
                    state_next = etrd_pkg::ST_STEP;
                end
            end
            etrd_pkg::ST_STEP: begin
                armed_next = armed_now;
                if (armed_now) begin
                    if (update_due) begin
                        ramp_mode_next   = mode_sel;
                        last_target_next = slew_val;
                        held_pulse_next  = slew_val;
                        last_update_next = time_reg;
                    end
                end else begin
                    last_target_next = neutral_center_reg;
                    held_pulse_next  = neutral_center_reg;
                end
                state_next = etrd_pkg::ST_MAP;
            end
            etrd_pkg::ST_MAP: begin
                if (map_fwd) begin
                    region_next = etrd_pkg::RGN_FWD;
                end else if (map_rev) begin
                    region_next = etrd_pkg::RGN_REV;
                end else begin
                    region_next = etrd_pkg::RGN_BRAKE;
                end
                acc_next      = '0;
                mcand_next    = {{(QW-PW){1'b0}}, num_mag};
                mplier_next   = span_mag;
                den_next      = den_mag;
                rem_next      = '0;
                q_neg_next    = map_rev ^ den_diff[PW] ^ span_diff[DW];
                den_zero_next = (den_diff == '0);
                cnt_next      = etrd_pkg::CNT_W'(etrd_pkg::MUL_STEPS - 1);
                if ((!map_fwd && !map_rev) || den_diff == '0) begin
                    state_next = etrd_pkg::ST_FIN;
                end else begin
                    state_next = etrd_pkg::ST_MUL;
                end
            end
            etrd_pkg::ST_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[QW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[etrd_pkg::SPAN_W-1:1]};
                if (cnt_reg == '0) begin
                    cnt_next   = etrd_pkg::CNT_W'(etrd_pkg::DIV_STEPS - 1);
                    state_next = etrd_pkg::ST_DIV;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            etrd_pkg::ST_DIV: begin
                // shift dividend out the top, quotient bits in the bottom
                rem_next = borrow ? rem_shift[PW-1:0] : trial[PW-1:0];
                acc_next = {acc_reg[QW-2:0], ~borrow};
                if (cnt_reg == '0) begin
                    state_next = etrd_pkg::ST_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            etrd_pkg::ST_FIN: begin
                if (out_free) begin
                    out_pulse_next = held_pulse_reg;
                    m_valid_next   = 1'b1;
                    state_next     = etrd_pkg::ST_IDLE;
                    case (region_reg)
                        etrd_pkg::RGN_FWD: begin
                            out_duty_next = duty_sel;
                            if (duty_sel != '0) begin
                                out_kind_next  = etrd_pkg::KIND_FWD;
                                out_drive_next = duty_s;
                            end else begin
                                out_kind_next  = etrd_pkg::KIND_BRAKE;
                                out_drive_next = '0;
                            end
                        end
                        etrd_pkg::RGN_REV: begin
                            out_duty_next = duty_sel;
                            if (duty_sel != '0) begin
                                out_kind_next  = etrd_pkg::KIND_REV;
                                out_drive_next = -duty_s;
                            end else begin
                                out_kind_next  = etrd_pkg::KIND_BRAKE;
                                out_drive_next = '0;
                            end
                        end
                        default: begin
                            out_duty_next  = etrd_pkg::DRAG_BRAKE_DUTY;
                            out_kind_next  = etrd_pkg::KIND_BRAKE;
                            out_drive_next = '0;
                        end
                    endcase
                end
            end
            default: state_next = etrd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= etrd_pkg::ST_IDLE;
            ramp_mode_reg   <= etrd_pkg::RAMP_EMERGENCY;
            region_reg      <= etrd_pkg::RGN_BRAKE;
            armed_reg       <= 1'b0;
            last_target_reg <= etrd_pkg::RST_NEUTRAL_CENTER;
            last_update_reg <= '0;
            held_pulse_reg  <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ramp_mode_reg   <= ramp_mode_next;
            region_reg      <= region_next;
            armed_reg       <= armed_next;
            last_target_reg <= last_target_next;
            last_update_reg <= last_update_next;
            held_pulse_reg  <= held_pulse_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pw_reg        <= pw_next;
        time_reg      <= time_next;
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        q_neg_reg     <= q_neg_next;
        den_zero_reg  <= den_zero_next;
        out_pulse_reg <= out_pulse_next;
        out_kind_reg  <= out_kind_next;
        out_duty_reg  <= out_duty_next;
        out_drive_reg <= out_drive_next;
    end

    // ---------------- assertions ----------------
    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a request is in progress");

    a_duty_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_channel_duty <= etrd_pkg::DUTY_LIMIT)
        else $error("channel duty above limit");

    a_brake_is_zero_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_kind == etrd_pkg::KIND_BRAKE |-> m_signed_drive == 0)
        else $error("brake result with nonzero signed drive");

    a_armed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |=> armed_reg)
        else $error("armed flag dropped");

    a_div_ends_in_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == etrd_pkg::ST_DIV && cnt_reg == '0 |=> state_reg == etrd_pkg::ST_FIN)
        else $error("divide did not finish on its last step");

endmodule

@@ tb/esc_throttle_ramp_drive_chk.sv @@
// Checker for esc_throttle_ramp_drive: tracks register writes, predicts the result
// of every accepted request and compares each returned result field by field.
// Depends on etrd_pkg for widths, codes and reset values.
`timescale 1ns / 1ps

module esc_throttle_ramp_drive_chk (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [etrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [etrd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [etrd_pkg::PULSE_W-1:0]         s_pulse_width,
    input  logic [etrd_pkg::TIME_W-1:0]          s_time_ms,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [etrd_pkg::PULSE_W-1:0]         m_ramped_pulse,
    input  logic [etrd_pkg::KIND_W-1:0]          m_drive_kind,
    input  logic [etrd_pkg::DUTY_W-1:0]          m_channel_duty,
    input  logic signed [etrd_pkg::DRIVE_W-1:0]  m_signed_drive,
    output int                                   fail_count,
    output int                                   drive_waiting
);
    localparam int PW = etrd_pkg::PULSE_W;
    localparam int TW = etrd_pkg::TIME_W;
    localparam int IW = etrd_pkg::INTERVAL_W;
    localparam int DW = etrd_pkg::DUTY_W;
    localparam int KW = etrd_pkg::KIND_W;
    localparam int RW = etrd_pkg::DRIVE_W;

    typedef struct packed {
        logic [PW-1:0] pulse;
        logic [KW-1:0] kind;
        logic [DW-1:0] duty;
        logic [RW-1:0] drive;
    } drive_t;

    // register copies
    logic [PW-1:0] band_low, band_high, center, accel, decel;
    logic [IW-1:0] ramp_gap;
    logic [DW-1:0] duty_floor, duty_ceil;

    // block state copies
    logic              armed;
    etrd_pkg::mode_t   mode;
    logic [PW-1:0]     last_tgt, held;
    logic [TW-1:0]     last_upd;

    drive_t drive_due[$];
    int     mism = 0;

    function automatic int map_duty(int x, int in0, int in1);
        int d;
        if (in1 == in0) begin
            d = int'(duty_ceil);
        end else begin
            d = (x - in0) * (int'(duty_ceil) - int'(duty_floor)) / (in1 - in0)
                + int'(duty_floor);
        end
        if (d > int'(etrd_pkg::DUTY_LIMIT)) d = int'(etrd_pkg::DUTY_LIMIT);
        if (d < 0) d = 0;
        return d;
    endfunction

    function automatic logic [PW-1:0] slew_toward(logic [PW-1:0] target);
        int tgt, prev, lo, hi, up, down, v;
        tgt  = int'(target);
        prev = int'(last_tgt);
        lo   = int'(band_low);
        hi   = int'(band_high);
        up   = int'(accel);
        down = int'(decel);
        // mode is sticky: emergency holds until the last target is back in the band
        if (prev > hi && mode != etrd_pkg::RAMP_EMERGENCY) mode = etrd_pkg::RAMP_FORWARD;
        else if (prev < lo && mode != etrd_pkg::RAMP_EMERGENCY)
            mode = etrd_pkg::RAMP_REVERSE;
        else if (prev >= lo && prev <= hi) mode = etrd_pkg::RAMP_STOPPED;
        else mode = etrd_pkg::RAMP_EMERGENCY;
        v = tgt;
        case (mode)
            etrd_pkg::RAMP_STOPPED: begin
                if (tgt > prev + up) v = prev + up;
                if (tgt < prev - up) v = prev - up;
            end
            etrd_pkg::RAMP_FORWARD: begin
                if (tgt > prev + up) v = prev + up;
                if (tgt < prev - down) v = prev - down;
            end
            etrd_pkg::RAMP_REVERSE: begin
                if (tgt < prev - up) v = prev - up;
                if (tgt > prev + down) v = prev + down;
            end
            default: ;
        endcase
        if (v < 0) v = 0;
        if (v > int'(etrd_pkg::PULSE_MAX)) v = int'(etrd_pkg::PULSE_MAX);
        last_tgt = v[PW-1:0];
        return v[PW-1:0];
    endfunction

    function automatic drive_t throttle_step(logic [PW-1:0] pw, logic [TW-1:0] now);
        drive_t r;
        int     x, duty;
        if (pw > band_low && pw < band_high) armed = 1'b1;
        if (armed) begin
            if (TW'(now - last_upd) > TW'(ramp_gap)) begin
                held     = slew_toward(pw);
                last_upd = now;
            end
        end else begin
            last_tgt = center;
            held     = center;
        end
        x       = int'(held);
        duty    = 0;
        r.kind  = etrd_pkg::KIND_BRAKE;
        r.drive = '0;
        if (x > int'(band_high)) begin
            duty = map_duty(x, int'(band_high), int'(etrd_pkg::FULL_FWD_PULSE));
            if (duty > 0) begin
                r.kind  = etrd_pkg::KIND_FWD;
                r.drive = RW'(duty);
            end
        end else if (x < int'(band_low)) begin
            duty = map_duty(x, int'(band_low), int'(etrd_pkg::FULL_REV_PULSE));
            if (duty > 0) begin
                r.kind  = etrd_pkg::KIND_REV;
                r.drive = RW'(-duty);
            end
        end else begin
            duty = int'(etrd_pkg::DRAG_BRAKE_DUTY);
        end
        r.pulse = held;
        r.duty  = duty[DW-1:0];
        return r;
    endfunction

    task automatic check_field(input string fname, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            mism++;
        end
    endtask

    always @(posedge aclk) begin
        drive_t want;
        if (!aresetn) begin
            band_low   = etrd_pkg::RST_NEUTRAL_LOW;
            band_high  = etrd_pkg::RST_NEUTRAL_HIGH;
            center     = etrd_pkg::RST_NEUTRAL_CENTER;
            ramp_gap   = etrd_pkg::RST_RAMP_INTERVAL;
            accel      = etrd_pkg::RST_ACCEL_STEP;
            decel      = etrd_pkg::RST_DECEL_STEP;
            duty_floor = etrd_pkg::RST_DUTY_FLOOR;
            duty_ceil  = etrd_pkg::RST_DUTY_CEILING;
            armed      = 1'b0;
            mode       = etrd_pkg::RAMP_EMERGENCY;
            last_tgt   = etrd_pkg::RST_NEUTRAL_CENTER;
            last_upd   = '0;
            held       = '0;
            drive_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    etrd_pkg::CFG_NEUTRAL_LOW:    band_low   = cfg_data[PW-1:0];
                    etrd_pkg::CFG_NEUTRAL_HIGH:   band_high  = cfg_data[PW-1:0];
                    etrd_pkg::CFG_NEUTRAL_CENTER: center     = cfg_data[PW-1:0];
                    etrd_pkg::CFG_RAMP_INTERVAL:  ramp_gap   = cfg_data[IW-1:0];
                    etrd_pkg::CFG_ACCEL_STEP:     accel      = cfg_data[PW-1:0];
                    etrd_pkg::CFG_DECEL_STEP:     decel      = cfg_data[PW-1:0];
                    etrd_pkg::CFG_DUTY_FLOOR:     duty_floor = cfg_data[DW-1:0];
                    etrd_pkg::CFG_DUTY_CEILING:   duty_ceil  = cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            // a result returned in this cycle always belongs to an older request
            if (m_valid && m_ready) begin
                if (drive_due.size() == 0) begin
                    $error("result with no request outstanding: ramped_pulse %0d",
                           m_ramped_pulse);
                    mism++;
                end else begin
                    want = drive_due.pop_front();
                    check_field("ramped_pulse", want.pulse, m_ramped_pulse);
                    check_field("drive_kind", want.kind, m_drive_kind);
                    check_field("channel_duty", want.duty, m_channel_duty);
                    check_field("signed_drive", $signed(want.drive), m_signed_drive);
                end
            end
            if (s_valid && s_ready)
                drive_due.push_back(throttle_step(s_pulse_width, s_time_ms));
        end
        fail_count    <= mism;
        drive_waiting <= drive_due.size();
    end

endmodule

@@ tb/esc_throttle_ramp_drive_tb.sv @@
// Top of the esc_throttle_ramp_drive testbench: clock, reset, register settings,
// directed and random requests under varying flow control, and the verdict.
// Depends on etrd_pkg, esc_throttle_ramp_drive and esc_throttle_ramp_drive_chk.
`timescale 1ns / 1ps

module esc_throttle_ramp_drive_tb;

    localparam int PW = etrd_pkg::PULSE_W;
    localparam int TW = etrd_pkg::TIME_W;
    localparam int IW = etrd_pkg::INTERVAL_W;
    localparam int XW = etrd_pkg::CFG_IDX_W;
    localparam int CW = etrd_pkg::CFG_DATA_W;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int DRAIN_CYCLES    = 40;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [XW-1:0]                       cfg_index;
    logic [CW-1:0]                       cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    logic [PW-1:0]                       s_pulse_width;
    logic [TW-1:0]                       s_time_ms;
    logic                                m_valid;
    logic                                m_ready;
    logic [PW-1:0]                       m_ramped_pulse;
    logic [etrd_pkg::KIND_W-1:0]         m_drive_kind;
    logic [etrd_pkg::DUTY_W-1:0]         m_channel_duty;
    logic signed [etrd_pkg::DRIVE_W-1:0] m_signed_drive;

    int fail_count;
    int drive_waiting;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int stall_pct    = 0;

    // register values as last written, used only to shape the stimulus
    logic [PW-1:0] low_now      = etrd_pkg::RST_NEUTRAL_LOW;
    logic [PW-1:0] high_now     = etrd_pkg::RST_NEUTRAL_HIGH;
    logic [IW-1:0] interval_now = etrd_pkg::RST_RAMP_INTERVAL;

    esc_throttle_ramp_drive DUT (.*);

    esc_throttle_ramp_drive_chk checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("esc_throttle_ramp_drive_tb: errors");
        $finish;
    end

    function automatic logic [PW-1:0] clamp_pulse(int v);
        if (v < 0) return '0;
        if (v > int'(etrd_pkg::PULSE_MAX)) return etrd_pkg::PULSE_MAX;
        return v[PW-1:0];
    endfunction

    // Hold cfg_valid high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [XW-1:0] idx, input logic [CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            etrd_pkg::CFG_NEUTRAL_LOW:   low_now      = data[PW-1:0];
            etrd_pkg::CFG_NEUTRAL_HIGH:  high_now     = data[PW-1:0];
            etrd_pkg::CFG_RAMP_INTERVAL: interval_now = data[IW-1:0];
            default: ;
        endcase
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input int lo, input int hi, input int ctr, input int ivl,
                                 input int up, input int down, input int flo, input int cei);
        write_reg(etrd_pkg::CFG_NEUTRAL_LOW, CW'(lo));
        write_reg(etrd_pkg::CFG_NEUTRAL_HIGH, CW'(hi));
        write_reg(etrd_pkg::CFG_NEUTRAL_CENTER, CW'(ctr));
        write_reg(etrd_pkg::CFG_RAMP_INTERVAL, CW'(ivl));
        write_reg(etrd_pkg::CFG_ACCEL_STEP, CW'(up));
        write_reg(etrd_pkg::CFG_DECEL_STEP, CW'(down));
        write_reg(etrd_pkg::CFG_DUTY_FLOOR, CW'(flo));
        write_reg(etrd_pkg::CFG_DUTY_CEILING, CW'(cei));
        cfg_valid <= 1'b0;
    endtask

    // Keep s_valid high into the next request unless a gap is drawn.
    task automatic send(input logic [PW-1:0] pw, input logic [TW-1:0] stamp);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pulse_width <= pw;
        s_time_ms     <= stamp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every result, then let the pipeline go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (drive_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [PW-1:0] aim;
        logic [PW-1:0] pw;
        logic [TW-1:0] clock_ms;
        int            roll;
        int            lo_pick;

        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= etrd_pkg::CFG_NEUTRAL_LOW;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_pulse_width <= '0;
        s_time_ms     <= '0;
        aim           = etrd_pkg::RST_NEUTRAL_CENTER;
        clock_ms      = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disarmed: band edges do not arm, the neutral center is held
        write_reg(etrd_pkg::CFG_NEUTRAL_CENTER, 16'd0);
        cfg_valid <= 1'b0;
        send(12'd0, 32'd0);
        send(12'd4095, 32'd1);
        send(12'd1480, 32'd2);
        send(12'd1520, 32'd3);
        settle();
        write_reg(etrd_pkg::CFG_NEUTRAL_CENTER, 16'd4095);
        cfg_valid <= 1'b0;
        send(12'd2000, 32'd4);
        settle();
        write_reg(etrd_pkg::CFG_NEUTRAL_CENTER, 16'd1700);
        cfg_valid <= 1'b0;
        send(12'd1000, 32'd5);
        // arm before the interval has passed: held pulse stays put
        send(12'd1500, 32'd6);
        // center outside the band keeps emergency mode: input passes straight through
        send(12'd1900, 32'd100);
        send(12'd1000, 32'd200);
        send(12'd4095, 32'd300);
        send(12'd0, 32'd400);
        send(12'd1500, 32'd500);
        // back in the band: stop ramp, then forward with accel and decel limits
        send(12'd2000, 32'd600);
        send(12'd2000, 32'd601);
        send(12'd2000, 32'd622);
        send(12'd2000, 32'd643);
        send(12'd2000, 32'd664);
        send(12'd1000, 32'd685);
        // time stamp wraps past zero
        send(12'd1530, 32'hFFFF_FFFF);
        send(12'd1530, 32'd20);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case (p)
                0: apply_setting(1480, 1520, 1500, 20, 10, 10, 0, 100);
                1: apply_setting(1480, 1520, 1500, 0, 4095, 4095, 0, 100);
                2: apply_setting(1400, 1600, 1500, 65535, 200, 50, 100, 0);
                3: apply_setting(1000, 2000, 1500, 5, 37, 90, 20, 80);
                4: apply_setting(0, 4095, 0, 1, 0, 0, 0, 0);
                5: apply_setting(1600, 1400, 4095, 30, 25, 300, 50, 100);
                6: begin
                    lo_pick = $urandom_range(1300, 1500);
                    apply_setting(lo_pick, lo_pick + $urandom_range(0, 200),
                                  $urandom_range(0, 4095), $urandom_range(0, 100),
                                  $urandom_range(1, 400), $urandom_range(1, 400),
                                  $urandom_range(0, 100), $urandom_range(0, 100));
                end
                default: apply_setting(1480, 1520, $urandom_range(0, 4095),
                                       $urandom_range(0, 40), $urandom_range(1, 60),
                                       $urandom_range(1, 60), $urandom_range(0, 100),
                                       $urandom_range(0, 100));
            endcase
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 77; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 77; end
                default: begin send_gap_pct = 7; stall_pct = 7; end
            endcase

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold a throttle target for a stretch so the ramp can reach it
                if (k % 12 == 0) begin
                    case ($urandom_range(0, 3))
                        0: aim = PW'($urandom_range(0, 4095));
                        1: aim = clamp_pulse(($urandom_range(0, 1) ? int'(low_now)
                                             : int'(high_now)) + $urandom_range(0, 6) - 3);
                        default: aim = PW'($urandom_range(950, 2050));
                    endcase
                end
                if ($urandom_range(0, 99) < 5)
                    pw = PW'($urandom_range(0, 4095));
                else
                    pw = clamp_pulse(int'(aim) + $urandom_range(0, 4) - 2);

                roll = $urandom_range(0, 99);
                if (roll < 8)
                    clock_ms = $urandom();
                else if (roll < 10)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
                else if (roll < 30)
                    clock_ms = clock_ms + $urandom_range(0, interval_now);
                else
                    clock_ms = clock_ms + interval_now + $urandom_range(1, 40);
                send(pw, clock_ms);
            end
        end
        settle();

        if (fail_count == 0)
            $display("esc_throttle_ramp_drive_tb: clean");
        else
            $display("esc_throttle_ramp_drive_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/etrd_pkg.sv
hw/rtl/esc_throttle_ramp_drive.sv
tb/esc_throttle_ramp_drive_chk.sv
tb/esc_throttle_ramp_drive_tb.sv
